@@ hw/rtl/ipsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ipsp_pkg
// Shared types and constants for the IPS patch stream parser.
// ----------------------------------------------------------------------------
package ipsp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ADDR_W  = 24;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned INDEX_W = 3;

   localparam logic [ADDR_W-1:0] END_MARKER = 24'h454F46;

   typedef enum logic [3:0] {
      PH_HEADER     = 4'd0,
      PH_HEADER_BAD = 4'd1,
      PH_ADDR       = 4'd2,
      PH_SIZE       = 4'd3,
      PH_DATA       = 4'd4,
      PH_RUN_LEN    = 4'd5,
      PH_FILL_BYTE  = 4'd6,
      PH_DONE       = 4'd7,
      PH_DEAD       = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_FILL  = 2'd1,
      KIND_END   = 2'd2,
      KIND_BAD   = 2'd3
   } kind_type;

   localparam logic [INDEX_W-1:0] HEADER_LAST = 3'd4;
   localparam logic [INDEX_W-1:0] ADDR_LAST   = 3'd2;
   localparam logic [INDEX_W-1:0] WORD_LAST   = 3'd1;

   // Expected header byte at each position of the text "PATCH".
   function automatic logic [BYTE_W-1:0] header_byte(input logic [INDEX_W-1:0] index);
      logic [BYTE_W-1:0] result;
      case (index)
         3'd0: begin
            result = 8'h50;
         end
         3'd1: begin
            result = 8'h41;
         end
         3'd2: begin
            result = 8'h54;
         end
         3'd3: begin
            result = 8'h43;
         end
         3'd4: begin
            result = 8'h48;
         end
         default: begin
            result = 8'h00;
         end
      endcase
      return result;
   endfunction

endpackage

@@ hw/rtl/ips_patch_stream_parser_core.sv @@
// ----------------------------------------------------------------------------
// ips_patch_stream_parser_core
// Parses an IPS patch byte stream into write, fill, end and bad-header results.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_stall   req_patch_byte
//   rsp_      out         rsp_valid/rsp_stall   rsp_kind, rsp_target_address,
//                                               rsp_run_length, rsp_byte_value
//
// One request is taken every cycle unless req_stall holds it; a request that produces a
// result presents it in the next cycle. The parser state and the result register are
// updated by the same edge. Reset is synchronous and clears the parser state and the
// result valid flag. A request is stalled only while a result is waiting and is itself stalled.
//
module ips_patch_stream_parser_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ipsp_pkg::BYTE_W-1:0]  req_patch_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [ipsp_pkg::ADDR_W-1:0]  rsp_target_address,
   output logic [ipsp_pkg::LEN_W-1:0]   rsp_run_length,
   output logic [ipsp_pkg::BYTE_W-1:0]  rsp_byte_value
);

   ipsp_pkg::phase_type               phase_ff, phase_in;
   logic [ipsp_pkg::INDEX_W-1:0]      index_ff, index_in;
   logic [ipsp_pkg::ADDR_W-1:0]       address_ff, address_in;
   logic [ipsp_pkg::LEN_W-1:0]        remaining_ff, remaining_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   ipsp_pkg::kind_type                kind_ff, kind_in;
   logic [ipsp_pkg::ADDR_W-1:0]       target_ff, target_in;
   logic [ipsp_pkg::LEN_W-1:0]        length_ff, length_in;
   logic [ipsp_pkg::BYTE_W-1:0]       value_ff, value_in;

   logic                              accept;
   logic                              emit;
   logic                              header_bad;
   logic [ipsp_pkg::ADDR_W-1:0]       address_shift;
   logic [ipsp_pkg::LEN_W-1:0]        remaining_shift;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign header_bad      = (req_patch_byte != ipsp_pkg::header_byte(index_ff))
                            || (phase_ff == ipsp_pkg::PH_HEADER_BAD);
   assign address_shift   = {address_ff[ipsp_pkg::ADDR_W-ipsp_pkg::BYTE_W-1:0], req_patch_byte};
   assign remaining_shift = {remaining_ff[ipsp_pkg::LEN_W-ipsp_pkg::BYTE_W-1:0], req_patch_byte};

   // Next parser state.
   always_comb begin
      phase_in     = phase_ff;
      index_in     = index_ff;
      address_in   = address_ff;
      remaining_in = remaining_ff;
      if (accept) begin
         case (phase_ff)
            ipsp_pkg::PH_HEADER, ipsp_pkg::PH_HEADER_BAD: begin
               if (index_ff == ipsp_pkg::HEADER_LAST) begin
                  index_in = '0;
                  if (header_bad) begin
                     phase_in = ipsp_pkg::PH_DEAD;
                  end else begin
                     phase_in   = ipsp_pkg::PH_ADDR;
                     address_in = '0;
                  end
               end else begin
                  index_in = index_ff + 3'd1;
                  phase_in = header_bad ? ipsp_pkg::PH_HEADER_BAD : ipsp_pkg::PH_HEADER;
               end
            end
            ipsp_pkg::PH_ADDR: begin
               address_in = address_shift;
               if (index_ff == ipsp_pkg::ADDR_LAST) begin
                  index_in = '0;
                  if (address_shift == ipsp_pkg::END_MARKER) begin
                     phase_in = ipsp_pkg::PH_DONE;
                  end else begin
                     phase_in     = ipsp_pkg::PH_SIZE;
                     remaining_in = '0;
                  end
               end else begin
                  index_in = index_ff + 3'd1;
               end
            end
            ipsp_pkg::PH_SIZE: begin
               remaining_in = remaining_shift;
               if (index_ff == ipsp_pkg::WORD_LAST) begin
                  index_in = '0;
                  phase_in = (remaining_shift == '0) ? ipsp_pkg::PH_RUN_LEN
                                                     : ipsp_pkg::PH_DATA;
               end else begin
                  index_in = index_ff + 3'd1;
               end
            end
            ipsp_pkg::PH_DATA: begin
               address_in   = address_ff + 24'd1;
               remaining_in = remaining_ff - 16'd1;
               if (remaining_ff == 16'd1) begin
                  phase_in   = ipsp_pkg::PH_ADDR;
                  address_in = '0;
                  index_in   = '0;
               end
            end
            ipsp_pkg::PH_RUN_LEN: begin
               remaining_in = remaining_shift;
               if (index_ff == ipsp_pkg::WORD_LAST) begin
                  index_in = '0;
                  phase_in = ipsp_pkg::PH_FILL_BYTE;
               end else begin
                  index_in = index_ff + 3'd1;
               end
            end
            ipsp_pkg::PH_FILL_BYTE: begin
               phase_in     = ipsp_pkg::PH_ADDR;
               index_in     = '0;
               address_in   = '0;
               remaining_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Result produced by the accepted request.
   always_comb begin
      emit      = 1'b0;
      kind_in   = ipsp_pkg::KIND_WRITE;
      target_in = '0;
      length_in = '0;
      value_in  = '0;
      case (phase_ff)
         ipsp_pkg::PH_HEADER, ipsp_pkg::PH_HEADER_BAD: begin
            if ((index_ff == ipsp_pkg::HEADER_LAST) && header_bad) begin
               emit    = 1'b1;
               kind_in = ipsp_pkg::KIND_BAD;
            end
         end
         ipsp_pkg::PH_ADDR: begin
            if ((index_ff == ipsp_pkg::ADDR_LAST) && (address_shift == ipsp_pkg::END_MARKER)) begin
               emit    = 1'b1;
               kind_in = ipsp_pkg::KIND_END;
            end
         end
         ipsp_pkg::PH_DATA: begin
            emit      = 1'b1;
            kind_in   = ipsp_pkg::KIND_WRITE;
            target_in = address_ff;
            length_in = 16'd1;
            value_in  = req_patch_byte;
         end
         ipsp_pkg::PH_FILL_BYTE: begin
            emit      = (remaining_ff != '0);
            kind_in   = ipsp_pkg::KIND_FILL;
            target_in = address_ff;
            length_in = remaining_ff;
            value_in  = req_patch_byte;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (accept && emit) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ipsp_pkg::PH_HEADER;
         index_ff     <= '0;
         address_ff   <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         address_ff   <= address_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff   <= kind_in;
         target_ff <= target_in;
         length_ff <= length_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_target_address = target_ff;
   assign rsp_run_length     = length_ff;
   assign rsp_byte_value     = value_ff;

   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_write_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == ipsp_pkg::KIND_WRITE)) |-> (rsp_run_length == 16'd1))
      else $error("write result with run length other than one");

   a_fill_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == ipsp_pkg::KIND_FILL)) |-> (rsp_run_length != '0))
      else $error("empty fill result");

   a_terminal_stays: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == ipsp_pkg::PH_DONE) || (phase_ff == ipsp_pkg::PH_DEAD))
      |=> $stable(phase_ff))
      else $error("parser left a terminal phase");

   a_status_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_kind == ipsp_pkg::KIND_END) || (rsp_kind == ipsp_pkg::KIND_BAD)))
      |-> ((rsp_target_address == '0) && (rsp_run_length == '0) && (rsp_byte_value == '0)))
      else $error("status result carries nonzero fields");

endmodule

@@ test/ips_patch_stream_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPS patch stream parser testbench
// Drives one well-formed patch through the parser byte by byte, with random
// request gaps and result stalls. A behavioural parser predicts every write,
// fill and end result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ITEM_COUNT  = 750;
   localparam int IDLE_LIMIT  = 2000;
   localparam logic [39:0] PATCH_TEXT = "PATCH";

   typedef struct {
      ipsp_pkg::kind_type                kind;
      logic [ipsp_pkg::ADDR_W-1:0]       address;
      logic [ipsp_pkg::LEN_W-1:0]        length;
      logic [ipsp_pkg::BYTE_W-1:0]       value;
   } edit_type;

   class edit_scoreboard;
      ipsp_pkg::phase_type               phase;
      logic [2:0]                        index;
      logic [ipsp_pkg::ADDR_W-1:0]       address;
      logic [ipsp_pkg::LEN_W-1:0]        remaining;
      edit_type                          pending_edits[$];
      int                                errors;
      int                                writes_seen;
      int                                fills_seen;
      int                                ends_seen;

      function new();
         phase       = ipsp_pkg::PH_HEADER;
         index       = '0;
         address     = '0;
         remaining   = '0;
         errors      = 0;
         writes_seen = 0;
         fills_seen  = 0;
         ends_seen   = 0;
      endfunction

      function void push_edit(ipsp_pkg::kind_type kind, logic [ipsp_pkg::ADDR_W-1:0] a,
                              logic [ipsp_pkg::LEN_W-1:0] n,
                              logic [ipsp_pkg::BYTE_W-1:0] v);
         edit_type e;
         e.kind    = kind;
         e.address = a;
         e.length  = n;
         e.value   = v;
         pending_edits.push_back(e);
      endfunction

      function void note_request(logic [ipsp_pkg::BYTE_W-1:0] b);
         case (phase)
            ipsp_pkg::PH_HEADER, ipsp_pkg::PH_HEADER_BAD: begin
               if (b != PATCH_TEXT[39 - 8 * index -: 8]) begin
                  phase = ipsp_pkg::PH_HEADER_BAD;
               end
               index = index + 3'd1;
               if (index >= 3'd5) begin
                  index = '0;
                  if (phase == ipsp_pkg::PH_HEADER_BAD) begin
                     phase = ipsp_pkg::PH_DEAD;
                     push_edit(ipsp_pkg::KIND_BAD, '0, '0, '0);
                  end else begin
                     phase   = ipsp_pkg::PH_ADDR;
                     address = '0;
                  end
               end
            end
            ipsp_pkg::PH_ADDR: begin
               address = {address[15:0], b};
               index   = index + 3'd1;
               if (index >= 3'd3) begin
                  index = '0;
                  if (address == ipsp_pkg::END_MARKER) begin
                     phase = ipsp_pkg::PH_DONE;
                     push_edit(ipsp_pkg::KIND_END, '0, '0, '0);
                  end else begin
                     phase     = ipsp_pkg::PH_SIZE;
                     remaining = '0;
                  end
               end
            end
            ipsp_pkg::PH_SIZE: begin
               remaining = {remaining[7:0], b};
               index     = index + 3'd1;
               if (index >= 3'd2) begin
                  index = '0;
                  phase = (remaining == '0) ? ipsp_pkg::PH_RUN_LEN : ipsp_pkg::PH_DATA;
               end
            end
            ipsp_pkg::PH_DATA: begin
               push_edit(ipsp_pkg::KIND_WRITE, address, 16'd1, b);
               address   = address + 24'd1;
               remaining = remaining - 16'd1;
               if (remaining == '0) begin
                  phase   = ipsp_pkg::PH_ADDR;
                  address = '0;
                  index   = '0;
               end
            end
            ipsp_pkg::PH_RUN_LEN: begin
               remaining = {remaining[7:0], b};
               index     = index + 3'd1;
               if (index >= 3'd2) begin
                  index = '0;
                  phase = ipsp_pkg::PH_FILL_BYTE;
               end
            end
            ipsp_pkg::PH_FILL_BYTE: begin
               if (remaining != '0) begin
                  push_edit(ipsp_pkg::KIND_FILL, address, remaining, b);
               end
               phase     = ipsp_pkg::PH_ADDR;
               index     = '0;
               address   = '0;
               remaining = '0;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(logic [1:0] kind, logic [ipsp_pkg::ADDR_W-1:0] a,
                                 logic [ipsp_pkg::LEN_W-1:0] n,
                                 logic [ipsp_pkg::BYTE_W-1:0] v);
         edit_type e;
         if (pending_edits.size() == 0) begin
            $display("%0t: unexpected result, actual kind %0d address %0h length %0h value %0h",
                     $time, kind, a, n, v);
            errors++;
            return;
         end
         e = pending_edits.pop_front();
         if (kind != e.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d", $time, e.kind, kind);
            errors++;
         end
         if (a != e.address) begin
            $display("%0t: address mismatch, expected %0h, actual %0h", $time, e.address, a);
            errors++;
         end
         if (n != e.length) begin
            $display("%0t: length mismatch, expected %0h, actual %0h", $time, e.length, n);
            errors++;
         end
         if (v != e.value) begin
            $display("%0t: value mismatch, expected %0h, actual %0h", $time, e.value, v);
            errors++;
         end
         case (e.kind)
            ipsp_pkg::KIND_WRITE: writes_seen++;
            ipsp_pkg::KIND_FILL:  fills_seen++;
            default:              ends_seen++;
         endcase
      endfunction
   endclass

   logic                              clock;
   logic                              reset          = 1'b1;
   logic                              req_valid      = 1'b0;
   logic                              req_stall;
   logic [ipsp_pkg::BYTE_W-1:0]       req_patch_byte = '0;
   logic                              rsp_valid;
   logic                              rsp_stall      = 1'b0;
   logic [1:0]                        rsp_kind;
   logic [ipsp_pkg::ADDR_W-1:0]       rsp_target_address;
   logic [ipsp_pkg::LEN_W-1:0]        rsp_run_length;
   logic [ipsp_pkg::BYTE_W-1:0]       rsp_byte_value;

   edit_scoreboard      sb;
   int                  sent_count  = 0;
   int                  burst_left  = 0;
   int                  idle_cycles = 0;
   logic [7:0]          stall_count = '0;
   logic [1:0]          stall_mode  = '0;

   ips_patch_stream_parser_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_patch_byte     (req_patch_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_target_address (rsp_target_address),
      .rsp_run_length     (rsp_run_length),
      .rsp_byte_value     (rsp_byte_value)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      stall_count <= stall_count + 8'd1;
      if (stall_count[6:0] == 7'd0) begin
         stall_mode <= 2'($urandom_range(0, 3));
      end
      case (stall_mode)
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_count[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_kind, rsp_target_address, rsp_run_length, rsp_byte_value);
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_patch_byte);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [ipsp_pkg::BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = int'($urandom_range(1, 30));
      end
      req_valid      <= 1'b1;
      req_patch_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   task automatic send_address(input logic [ipsp_pkg::ADDR_W-1:0] a);
      send_byte(a[23:16]);
      send_byte(a[15:8]);
      send_byte(a[7:0]);
   endtask

   task automatic send_word(input logic [ipsp_pkg::LEN_W-1:0] w);
      send_byte(w[15:8]);
      send_byte(w[7:0]);
   endtask

   task automatic send_fill(input logic [ipsp_pkg::ADDR_W-1:0] a,
                            input logic [ipsp_pkg::LEN_W-1:0] n,
                            input logic [ipsp_pkg::BYTE_W-1:0] v);
      send_address(a);
      send_word(16'd0);
      send_word(n);
      send_byte(v);
   endtask

   initial begin
      logic [ipsp_pkg::ADDR_W-1:0] address;
      logic [ipsp_pkg::LEN_W-1:0]  size;
      int                          pick;
      int                          style;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 5; i++) begin
         send_byte(PATCH_TEXT[39 - 8 * i -: 8]);
      end
      send_address(24'hFFFFFE);
      send_word(16'h0003);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_fill(24'h454F47, 16'hFFFF, 8'hFF);
      send_fill(24'h000000, 16'h0000, 8'hA5);

      while (sent_count < ITEM_COUNT) begin
         pick  = int'($urandom_range(0, 99));
         style = int'($urandom_range(0, 9));
         case (style)
            0: address = 24'hFFFFFF - 24'($urandom_range(0, 15));
            1: address = {8'h45, 8'h4F, 8'($urandom_range(0, 255))};
            2: address = {8'h45, 8'($urandom_range(0, 255)), 8'h46};
            default: address = 24'($urandom);
         endcase
         if (address == ipsp_pkg::END_MARKER) begin
            address = address ^ 24'h000001;
         end
         if (pick < 65) begin
            size = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 60))
                                               : 16'($urandom_range(1, 12));
            send_address(address);
            send_word(size);
            repeat (size) send_byte(8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 3))
               0: size = '0;
               1: size = 16'($urandom_range(1, 255));
               default: size = 16'($urandom);
            endcase
            send_fill(address, size, 8'($urandom_range(0, 255)));
         end
      end

      send_address(ipsp_pkg::END_MARKER);
      repeat ($urandom_range(4, 12)) send_byte(8'($urandom_range(0, 255)));
      req_valid <= 1'b0;
      while (sb.pending_edits.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d patch bytes with random gaps and result stalls.", sent_count);
      $display("Checked %0d writes, %0d fills and %0d end results.",
               sb.writes_seen, sb.fills_seen, sb.ends_seen);
      if (sb.errors == 0 && sb.pending_edits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ipsp_pkg.sv
hw/rtl/ips_patch_stream_parser_core.sv
test/ips_patch_stream_parser_tb.sv
